// ===== src/vhf_pkg.sv =====
// ----------------------------------------------------------------------------
// Verhoeff check digit package
// Constant tables of the dihedral group of order 10 and lookup functions
// for the check digit datapath; its checker shares only the widths and DIGIT_MAX.
// ----------------------------------------------------------------------------
package vhf_pkg;

    // Width of one decimal digit and of the digit position counter.
    localparam int DIGIT_W = 4;
    localparam int POS_W   = 3;
    localparam int RADIX   = 10;
    localparam int TDATA_W = 8;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [POS_W-1:0]   pos_t;

    // Multiplication table of the dihedral group D5.
    localparam digit_t MUL_TAB [RADIX][RADIX] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9},
        '{4'd1, 4'd2, 4'd3, 4'd4, 4'd0, 4'd6, 4'd7, 4'd8, 4'd9, 4'd5},
        '{4'd2, 4'd3, 4'd4, 4'd0, 4'd1, 4'd7, 4'd8, 4'd9, 4'd5, 4'd6},
        '{4'd3, 4'd4, 4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd5, 4'd6, 4'd7},
        '{4'd4, 4'd0, 4'd1, 4'd2, 4'd3, 4'd9, 4'd5, 4'd6, 4'd7, 4'd8},
        '{4'd5, 4'd9, 4'd8, 4'd7, 4'd6, 4'd0, 4'd4, 4'd3, 4'd2, 4'd1},
        '{4'd6, 4'd5, 4'd9, 4'd8, 4'd7, 4'd1, 4'd0, 4'd4, 4'd3, 4'd2},
        '{4'd7, 4'd6, 4'd5, 4'd9, 4'd8, 4'd2, 4'd1, 4'd0, 4'd4, 4'd3},
        '{4'd8, 4'd7, 4'd6, 4'd5, 4'd9, 4'd3, 4'd2, 4'd1, 4'd0, 4'd4},
        '{4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0}
    };

    // Position-dependent permutations, one row per position modulo 8.
    localparam digit_t PERM_TAB [8][RADIX] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9},
        '{4'd1, 4'd5, 4'd7, 4'd6, 4'd2, 4'd8, 4'd3, 4'd0, 4'd9, 4'd4},
        '{4'd5, 4'd8, 4'd0, 4'd3, 4'd7, 4'd9, 4'd6, 4'd1, 4'd4, 4'd2},
        '{4'd8, 4'd9, 4'd1, 4'd6, 4'd0, 4'd4, 4'd3, 4'd5, 4'd2, 4'd7},
        '{4'd9, 4'd4, 4'd5, 4'd3, 4'd1, 4'd2, 4'd6, 4'd8, 4'd7, 4'd0},
        '{4'd4, 4'd2, 4'd8, 4'd6, 4'd5, 4'd7, 4'd3, 4'd9, 4'd0, 4'd1},
        '{4'd2, 4'd7, 4'd9, 4'd3, 4'd8, 4'd0, 4'd6, 4'd4, 4'd1, 4'd5},
        '{4'd7, 4'd0, 4'd4, 4'd6, 4'd9, 4'd1, 4'd3, 4'd2, 4'd5, 4'd8}
    };

    // Group inverse of each element.
    localparam digit_t INV_TAB [RADIX] = '{
        4'd0, 4'd4, 4'd3, 4'd2, 4'd1, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9
    };

    localparam digit_t DIGIT_MAX = digit_t'(RADIX - 1);

    // Fold an out-of-range digit code 10..15 down to 0..5.
    function automatic digit_t vhf_fold(input digit_t d);
        return (d > DIGIT_MAX) ? digit_t'(d - digit_t'(RADIX)) : d;
    endfunction

    function automatic digit_t vhf_mul(input digit_t a, input digit_t b);
        return (a <= DIGIT_MAX && b <= DIGIT_MAX) ? MUL_TAB[a][b] : '0;
    endfunction

    function automatic digit_t vhf_perm(input pos_t p, input digit_t d);
        return (d <= DIGIT_MAX) ? PERM_TAB[p][d] : '0;
    endfunction

    function automatic digit_t vhf_inv(input digit_t a);
        return (a <= DIGIT_MAX) ? INV_TAB[a] : '0;
    endfunction

endpackage

// ===== src/verhoeff_check_digit_top.sv =====
// ----------------------------------------------------------------------------
// Verhoeff check digit engine
// Streams decimal digits, least significant first, and on the digit marked
// with tlast returns the check digit to append and a validity flag.
// ----------------------------------------------------------------------------
// The block takes one digit per cycle with no gaps between numbers. A digit
// enters an input register and is then folded into both accumulators through
// two table lookups, and the result of a number appears on the master side
// once its last digit has reached the result register. The output register
// frees the input side while a result waits: digits that do not end a number
// keep flowing, and only a last digit stalls until the waiting result has
// been taken. Only requests with s_axis_tlast set produce a result.
module verhoeff_check_digit_top
    import vhf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [TDATA_W-1:0]  s_axis_tdata,   // [3:0] digit, [7:4] zero
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [TDATA_W-1:0]  m_axis_tdata    // [3:0] check_digit, [4] valid_res
);

    logic   in_valid_reg;
    digit_t in_digit_reg;
    logic   in_last_reg;

    digit_t gen_accum_reg, gen_accum_next;
    digit_t check_accum_reg, check_accum_next;
    pos_t   position_reg;

    logic   out_valid_reg;
    digit_t out_check_reg;
    logic   out_res_reg;

    logic   out_free;
    logic   in_move;
    logic   s_accept;

    // Pipeline flow: a last digit waits only for a free output register.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_move       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || in_move;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_accept) begin
            in_digit_reg <= vhf_fold(s_axis_tdata[DIGIT_W-1:0]);
            in_last_reg  <= s_axis_tlast;
        end
    end

    // Accumulator update for the digit in the input register.
    always_comb begin
        gen_accum_next   = vhf_mul(gen_accum_reg,
                                   vhf_perm(pos_t'(position_reg + 1'b1), in_digit_reg));
        check_accum_next = vhf_mul(check_accum_reg, vhf_perm(position_reg, in_digit_reg));
    end

    // Accumulator and position state, cleared at the end of each number.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_accum_reg   <= '0;
            check_accum_reg <= '0;
            position_reg    <= '0;
        end else if (in_move) begin
            if (in_last_reg) begin
                gen_accum_reg   <= '0;
                check_accum_reg <= '0;
                position_reg    <= '0;
            end else begin
                gen_accum_reg   <= gen_accum_next;
                check_accum_reg <= check_accum_next;
                position_reg    <= pos_t'(position_reg + 1'b1);
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_move && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (in_move && in_last_reg) begin
            out_check_reg <= vhf_inv(gen_accum_next);
            out_res_reg   <= (check_accum_next == '0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W-DIGIT_W-1){1'b0}}, out_res_reg, out_check_reg};

endmodule

// ===== src/vhf_checker.sv =====
// ----------------------------------------------------------------------------
// Verhoeff check digit port checker
// Watches the ports of the check digit engine and flags illegal behavior.
// ----------------------------------------------------------------------------
module vhf_checker
    import vhf_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               s_axis_tlast,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata
);

    logic s_last_accept;

    assign s_last_accept = s_axis_tvalid && s_axis_tready && s_axis_tlast;

    // A stalled result holds its request and its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // A new result only follows an accepted last digit.
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_last_accept, 2))
        else $error("result without a preceding last digit");

    // A check digit is always a decimal digit and the padding stays zero.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[DIGIT_W-1:0] <= DIGIT_MAX) &&
                          (m_axis_tdata[TDATA_W-1:DIGIT_W+1] == '0))
        else $error("check digit out of range");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind verhoeff_check_digit_top vhf_checker u_vhf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
